[rtl/core/rcat_pkg.sv]
// Package with the microcode format, control program and status codes of the ack tracker.
`timescale 1ns / 1ps

package rcat_pkg;

  localparam int unsigned SeqWidth = 16;
  localparam int unsigned RingTop  = 65535;
  localparam int unsigned RingSize = 65535;

  typedef enum logic [1:0] {
    ST_HELD = 2'd0,
    ST_ADV  = 2'd1,
    ST_DUP  = 2'd2,
    ST_OOW  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CLASS,
    OP_HOLD,
    OP_ADV,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_OOW,
    C_ADV,
    C_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef logic [2:0] step_t;

  localparam step_t S_WAIT  = 3'd0;
  localparam step_t S_CLASS = 3'd1;
  localparam step_t S_SPLIT = 3'd2;
  localparam step_t S_HOLD  = 3'd3;
  localparam step_t S_ADV   = 3'd4;
  localparam step_t S_EMIT  = 3'd5;
  localparam step_t S_DONE  = 3'd6;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ctrl_word_t;

  // Condition inputs that the datapath hands to the sequencer.
  typedef struct packed {
    logic in_valid;
    logic oow;
    logic adv;
    logic more;
    logic out_busy;
  } seq_flags_t;

  // The control program. A jump is taken when its condition holds; otherwise
  // the step counter moves on by one.
  function automatic ctrl_word_t ucode_rom(step_t step);
    ctrl_word_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: S_WAIT};
    unique case (step)
      S_WAIT:  w = '{op: OP_ACCEPT, cond: C_NO_IN,    target: S_WAIT};
      S_CLASS: w = '{op: OP_CLASS,  cond: C_OOW,      target: S_EMIT};
      S_SPLIT: w = '{op: OP_NONE,   cond: C_ADV,      target: S_ADV};
      S_HOLD:  w = '{op: OP_HOLD,   cond: C_ALWAYS,   target: S_EMIT};
      S_ADV:   w = '{op: OP_ADV,    cond: C_MORE,     target: S_ADV};
      S_EMIT:  w = '{op: OP_EMIT,   cond: C_OUT_BUSY, target: S_EMIT};
      S_DONE:  w = '{op: OP_NONE,   cond: C_ALWAYS,   target: S_WAIT};
      default: w = '{op: OP_NONE,   cond: C_ALWAYS,   target: S_WAIT};
    endcase
    return w;
  endfunction

endpackage

[rtl/core/rcat_if.sv]
// Request channel interfaces for the ack tracker input and result streams.
`timescale 1ns / 1ps

interface rcat_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] seq_num;

  modport source (output valid, output seq_num, input ready);
  modport sink   (input valid, input seq_num, output ready);
endinterface

interface rcat_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] cum_ack_out;
  logic        ack_request;

  modport source (output valid, output status, output cum_ack_out, output ack_request,
                  input ready);
  modport sink   (input valid, input status, input cum_ack_out, input ack_request,
                  output ready);
endinterface

[rtl/core/rcat_seq.sv]
// Microcode sequencer: step counter, control store and conditional jump logic.
`timescale 1ns / 1ps

module rcat_seq
  import rcat_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  seq_flags_t flags_i,
  output ctrl_word_t ctrl_o
);

  step_t      pc_q, pc_d;
  ctrl_word_t word;
  logic       taken;

  assign word   = ucode_rom(pc_q);
  assign ctrl_o = word;

  always_comb begin
    case (word.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_IN:    taken = !flags_i.in_valid;
      C_OOW:      taken = flags_i.oow;
      C_ADV:      taken = flags_i.adv;
      C_MORE:     taken = flags_i.more;
      C_OUT_BUSY: taken = flags_i.out_busy;
      default:    taken = 1'b0;
    endcase
    pc_d = taken ? word.target : step_t'(pc_q + step_t'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

[rtl/core/receive_cumulative_ack_tracker_top.sv]
// Top level of the receive cumulative ack tracker: datapath around the microcode sequencer.
// A request is classified after acceptance: out of window goes straight to emit, held or
// duplicate passes a hold step, and in order advances the ack point one place per advance
// step (up to WINDOW places). Its result then waits for the output register to drain.
// One request is in work at a time.
// Reset clears the ack point to zero, empties the held bitmap and the output register.
`timescale 1ns / 1ps

module receive_cumulative_ack_tracker_top
  import rcat_pkg::*;
#(
  parameter int unsigned WINDOW = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  rcat_in_if.sink    in_i,
  rcat_out_if.source out_o
);

  localparam int unsigned IdxWidth = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  ctrl_word_t ctrl;
  seq_flags_t flags;

  logic [SeqWidth-1:0] seq_q;
  logic [SeqWidth-1:0] cum_q;
  logic [WINDOW-1:0]   map_q;
  logic [IdxWidth-1:0] idx_q;
  logic [1:0]          status_q;

  logic                out_valid_q;
  logic [1:0]          out_status_q;
  logic [SeqWidth-1:0] out_cum_q;
  logic                out_req_q;

  logic [SeqWidth-1:0] pos_seq, pos_cum, ring_dist;
  logic [SeqWidth:0]   diff;
  logic                oow, adv, out_busy, emit;
  logic [SeqWidth-1:0] cum_next;

  // Ring positions: 0 sits where 65535 does.
  assign pos_seq   = seq_q - SeqWidth'(1);
  assign pos_cum   = (cum_q == '0) ? SeqWidth'(RingSize - 1) : cum_q - SeqWidth'(1);
  assign diff      = {1'b0, pos_seq} - {1'b0, pos_cum};
  assign ring_dist = diff[SeqWidth] ? SeqWidth'(diff + (SeqWidth + 1)'(RingSize))
                                    : diff[SeqWidth-1:0];

  assign oow = (seq_q == '0) || (ring_dist == '0) || (ring_dist > SeqWidth'(WINDOW));
  assign adv = (ring_dist == SeqWidth'(1));

  assign cum_next = (cum_q == SeqWidth'(RingTop)) ? SeqWidth'(1) : cum_q + SeqWidth'(1);

  assign out_busy = out_valid_q && !out_o.ready;
  assign emit     = (ctrl.op == OP_EMIT) && !out_busy;

  assign flags = '{in_valid: in_i.valid, oow: oow, adv: adv,
                   more: map_q[1], out_busy: out_busy};

  rcat_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  assign in_i.ready = (ctrl.op == OP_ACCEPT);

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      seq_q <= in_i.seq_num;
    end
    case (ctrl.op)
      OP_CLASS: begin
        idx_q    <= ring_dist[IdxWidth-1:0] - IdxWidth'(1);
        status_q <= ST_OOW;
      end
      OP_HOLD: begin
        status_q <= map_q[idx_q] ? ST_DUP : ST_HELD;
      end
      OP_ADV: begin
        status_q <= ST_ADV;
      end
      default: begin
      end
    endcase
  end

  // Ack point and held bitmap; each advance step shifts out the bit being passed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cum_q <= '0;
      map_q <= '0;
    end else begin
      case (ctrl.op)
        OP_HOLD: begin
          map_q[idx_q] <= 1'b1;
        end
        OP_ADV: begin
          cum_q <= cum_next;
          map_q <= {1'b0, map_q[WINDOW-1:1]};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= status_q;
      out_cum_q    <= cum_q;
      out_req_q    <= (status_q == ST_ADV);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.cum_ack_out = out_cum_q;
  assign out_o.ack_request = out_req_q;

endmodule
